[design/can_j1939_frame_deframer_top_assert.svh]
// Assertion macros for the deframer RTL.
// Depends on nothing; included by cjd_queue, which carries concurrent checks.
`ifndef CAN_J1939_FRAME_DEFRAMER_TOP_ASSERT_SVH
`define CAN_J1939_FRAME_DEFRAMER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CJD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cjd assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define CJD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cjd assertion failed");

`endif

[design/cjd_pkg.sv]
// Package for the J1939 frame deframer: constants, entry kinds, queue entry.
// No dependencies; imported by every deframer module.
`default_nettype none
package cjd_pkg;

    localparam int          MAX_DATA_BYTES   = 8;
    localparam int          QUEUE_DEPTH_DEF  = 4;
    localparam logic [8:0]  HDR_BYTES        = 9'd5;
    localparam logic [8:0]  LAST_ID_POS      = 9'd4;
    localparam logic [7:0]  PDU2_FIRST_PF    = 8'd240;

    // What a byte is within its frame
    typedef enum logic [1:0] {
        K_LEN  = 2'd0,
        K_ID   = 2'd1,
        K_DATA = 2'd2
    } t_kind;

    // Classified byte handed from front to back
    typedef struct packed {
        logic [7:0] data_byte;
        t_kind      kind;
        logic [2:0] sub;   // id byte or data byte index
        logic       keep;  // data byte lands in the payload
        logic       last;  // byte closes the frame
    } t_entry;

endpackage
`default_nettype wire

[design/cjd_front.sv]
// Front end: tracks frame position and classifies each accepted byte.
// Depends on cjd_pkg.
`default_nettype none
module cjd_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_accept,
    input  wire logic [7:0]    i_byte_in,
    output cjd_pkg::t_entry    o_entry
);
    import cjd_pkg::*;

    logic [8:0] r_pos, n_pos;
    logic [7:0] r_len, n_len;
    logic [8:0] idx;

    // Classify the byte at the current position
    always_comb begin
        idx             = r_pos - HDR_BYTES;
        n_pos           = r_pos;
        n_len           = r_len;
        o_entry.data_byte = i_byte_in;
        o_entry.kind    = K_LEN;
        o_entry.sub     = '0;
        o_entry.keep    = 1'b0;
        o_entry.last    = 1'b0;
        if (r_pos == '0) begin
            n_len = i_byte_in;
            n_pos = 9'd1;
        end else if (r_pos < HDR_BYTES) begin
            o_entry.kind = K_ID;
            o_entry.sub  = r_pos[2:0] - 3'd1;
            o_entry.last = (r_pos == LAST_ID_POS) && (r_len == '0);
            n_pos        = o_entry.last ? '0 : r_pos + 9'd1;
        end else begin
            o_entry.kind = K_DATA;
            o_entry.sub  = idx[2:0];
            o_entry.keep = idx < 9'(MAX_DATA_BYTES);
            o_entry.last = ({1'b0, idx} + 10'd1) >= {2'b00, r_len};
            n_pos        = o_entry.last ? '0 : r_pos + 9'd1;
        end
    end

    // Position state advances per accepted transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_len <= '0;
        end else if (i_accept) begin
            r_pos <= n_pos;
            r_len <= n_len;
        end
    end

endmodule
`default_nettype wire

[design/cjd_queue.sv]
// Small register queue between front and back ends.
// Depends on cjd_pkg and the assertion macro header.
`default_nettype none
`include "can_j1939_frame_deframer_top_assert.svh"
module cjd_queue #(
    parameter int DEPTH = cjd_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire cjd_pkg::t_entry i_data,
    output logic               o_full,
    output logic               o_nonempty,
    input  wire logic          i_pop,
    output cjd_pkg::t_entry    o_data
);
    import cjd_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_entry             r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr, r_rd;
    logic [CNT_W-1:0]   r_count;

    assign o_full     = r_count == CNT_W'(DEPTH);
    assign o_nonempty = r_count != '0;
    assign o_data     = r_mem[r_rd];

    // Storage write
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    `CJD_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(DEPTH))
    `CJD_ASSERT_IMP(a_no_pop_empty, i_clk, i_rst_n, i_pop, o_nonempty)
    `CJD_ASSERT_IMP(a_no_push_full, i_clk, i_rst_n, i_push, !o_full)
    `CJD_ASSERT_NXT(a_count_up, i_clk, i_rst_n, i_push && !i_pop,
        r_count == $past(r_count) + CNT_W'(1))

endmodule
`default_nettype wire

[design/cjd_back.sv]
// Back end: assembles identifier and data, decodes the frame into the output register.
// Depends on cjd_pkg.
`default_nettype none
module cjd_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_q_nonempty,
    input  wire cjd_pkg::t_entry i_q_data,
    output logic               o_q_pop,
    output logic               o_valid,
    input  wire logic          i_stall,
    output logic [7:0]         o_data_len,
    output logic [2:0]         o_priority_res,
    output logic [1:0]         o_edp_dp,
    output logic [7:0]         o_pdu_format,
    output logic [7:0]         o_pdu_specific,
    output logic [17:0]        o_group_number,
    output logic [7:0]         o_source_addr,
    output logic [63:0]        o_payload,
    output logic               o_oversize
);
    import cjd_pkg::*;

    logic [7:0]  r_len, n_len;
    logic [31:0] r_id, n_id;
    logic [63:0] r_dat, n_dat;
    logic        r_valid;
    logic        can_load, done;
    logic [17:0] pgn;

    // Pop unless a closing byte would hit a held result
    assign can_load = !r_valid || !i_stall;
    assign o_q_pop  = i_q_nonempty && (!i_q_data.last || can_load);
    assign done     = o_q_pop && i_q_data.last;
    assign o_valid  = r_valid;

    // Accumulate the popped byte
    always_comb begin
        n_len = r_len;
        n_id  = r_id;
        n_dat = r_dat;
        case (i_q_data.kind)
            K_LEN: begin
                n_len = i_q_data.data_byte;
                n_id  = '0;
                n_dat = '0;
            end
            K_ID: begin
                n_id[{i_q_data.sub[1:0], 3'b000} +: 8] = i_q_data.data_byte;
            end
            K_DATA: begin
                if (i_q_data.keep) begin
                    n_dat[{i_q_data.sub, 3'b000} +: 8] = i_q_data.data_byte;
                end
            end
            default: begin
                n_len = r_len;
            end
        endcase
    end

    // PGN with PS kept only for PDU2
    assign pgn = {n_id[25:16], (n_id[23:16] >= PDU2_FIRST_PF) ? n_id[15:8] : 8'h00};

    // Assembly registers
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_len <= n_len;
            r_id  <= n_id;
            r_dat <= n_dat;
        end
    end

    // Output register payload
    always_ff @(posedge i_clk) begin
        if (done) begin
            o_data_len     <= r_len;
            o_priority_res <= n_id[28:26];
            o_edp_dp       <= pgn[17:16];
            o_pdu_format   <= pgn[15:8];
            o_pdu_specific <= n_id[15:8];
            o_group_number <= pgn;
            o_source_addr  <= n_id[7:0];
            o_payload      <= n_dat;
            o_oversize     <= r_len > 8'(MAX_DATA_BYTES);
        end
    end

    // Output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (done) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

endmodule
`default_nettype wire

[design/can_j1939_frame_deframer_top.sv]
// J1939 frame deframer: one byte per cycle in while o_stall is low, one decoded frame out per frame.
// Result is registered: the last byte is written to the queue, popped by the back end, then loads the output register.
// Throughput: 1 byte per cycle while the queue is not full, set by the front position counter and queue push.
// The queue absorbs output stalls; o_stall rises only when the queue is full.
// Reset (synchronous, active low) clears position, queue pointers and output valid.
// Depends on cjd_pkg, cjd_front, cjd_queue, cjd_back.
`default_nettype none
module can_j1939_frame_deframer_top #(
    parameter int QUEUE_DEPTH = cjd_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_stall,
    input  wire logic [7:0]    i_byte_in,
    output logic               o_valid,
    input  wire logic          i_stall,
    output logic [7:0]         o_data_len,
    output logic [2:0]         o_priority_res,
    output logic [1:0]         o_edp_dp,
    output logic [7:0]         o_pdu_format,
    output logic [7:0]         o_pdu_specific,
    output logic [17:0]        o_group_number,
    output logic [7:0]         o_source_addr,
    output logic [63:0]        o_payload,
    output logic               o_oversize
);
    import cjd_pkg::*;

    logic   accept, q_full, q_nonempty, q_pop;
    t_entry f_entry, q_entry;

    assign o_stall = q_full;
    assign accept  = i_valid && !q_full;

    cjd_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_byte_in (i_byte_in),
        .o_entry   (f_entry)
    );

    cjd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (accept),
        .i_data     (f_entry),
        .o_full     (q_full),
        .o_nonempty (q_nonempty),
        .i_pop      (q_pop),
        .o_data     (q_entry)
    );

    cjd_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_nonempty   (q_nonempty),
        .i_q_data       (q_entry),
        .o_q_pop        (q_pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_data_len     (o_data_len),
        .o_priority_res (o_priority_res),
        .o_edp_dp       (o_edp_dp),
        .o_pdu_format   (o_pdu_format),
        .o_pdu_specific (o_pdu_specific),
        .o_group_number (o_group_number),
        .o_source_addr  (o_source_addr),
        .o_payload      (o_payload),
        .o_oversize     (o_oversize)
    );

endmodule
`default_nettype wire

[verif/can_j1939_frame_deframer_top_tb.sv]
// Self-checking testbench for the J1939 frame deframer: byte stream in, decoded frames out.
// Holds its own frame decoder in a small scoreboard class; depends on cjd_pkg and the top.
`timescale 1ns / 1ps
module can_j1939_frame_deframer_top_tb;
    import cjd_pkg::*;

    localparam int N_BYTES    = 1500;
    localparam int LONG_HOLD  = 200;
    localparam int TAIL_WAIT  = 8;

    // One decoded frame, field for field as the block presents it
    typedef struct packed {
        logic [7:0]  data_len;
        logic [2:0]  prio;
        logic [1:0]  edp_dp;
        logic [7:0]  pf;
        logic [7:0]  ps;
        logic [17:0] pgn;
        logic [7:0]  sa;
        logic [63:0] payload;
        logic        oversize;
    } t_frame;

    // Frame decoder plus queue of frames still to come out of the block
    class j1939_frame_model;
        logic [8:0]  pos;
        logic [7:0]  flen;
        logic [31:0] id_word;
        logic [63:0] data_word;
        t_frame      decoded[$];
        int          mismatch_cnt;

        function new();
            pos          = '0;
            flen         = '0;
            id_word      = '0;
            data_word    = '0;
            mismatch_cnt = 0;
        endfunction

        // Close the current frame and queue its decode
        task close_frame();
            t_frame f;
            f.data_len = flen;
            f.prio     = id_word[28:26];
            if (id_word[23:16] >= PDU2_FIRST_PF)
                f.pgn = id_word[25:8];
            else
                f.pgn = {id_word[25:16], 8'h00};
            f.edp_dp   = f.pgn[17:16];
            f.pf       = f.pgn[15:8];
            f.ps       = id_word[15:8];
            f.sa       = id_word[7:0];
            f.payload  = data_word;
            f.oversize = (int'(flen) > MAX_DATA_BYTES);
            decoded.push_back(f);
            pos = '0;
        endtask

        // Advance the decoder by one accepted input transaction
        task take_byte(logic [7:0] b);
            int idx;
            if (pos == 0) begin
                flen      = b;
                id_word   = '0;
                data_word = '0;
                pos       = 9'd1;
            end else if (pos < HDR_BYTES) begin
                id_word = id_word | ({24'd0, b} << (8 * (int'(pos) - 1)));
                if (pos == LAST_ID_POS && flen == 0)
                    close_frame();
                else
                    pos = pos + 9'd1;
            end else begin
                idx = int'(pos) - int'(HDR_BYTES);
                if (idx < MAX_DATA_BYTES)
                    data_word = data_word | ({56'd0, b} << (8 * idx));
                if (idx + 1 >= int'(flen))
                    close_frame();
                else
                    pos = pos + 9'd1;
            end
        endtask

        task flag(string msg);
            $display("tb mismatch: %s", msg);
            mismatch_cnt++;
        endtask

        task cmp(string name, logic [63:0] got, logic [63:0] want);
            if (got !== want)
                flag($sformatf("%s got %0h want %0h", name, got, want));
        endtask

        // Check one output transaction against the oldest pending frame
        task match_frame(t_frame got);
            t_frame want;
            if (decoded.size() == 0) begin
                flag("frame out with none pending");
                return;
            end
            want = decoded.pop_front();
            cmp("data_len", 64'(got.data_len), 64'(want.data_len));
            cmp("priority", 64'(got.prio), 64'(want.prio));
            cmp("edp_dp", 64'(got.edp_dp), 64'(want.edp_dp));
            cmp("pdu_format", 64'(got.pf), 64'(want.pf));
            cmp("pdu_specific", 64'(got.ps), 64'(want.ps));
            cmp("group_number", 64'(got.pgn), 64'(want.pgn));
            cmp("source_addr", 64'(got.sa), 64'(want.sa));
            cmp("payload", got.payload, want.payload);
            cmp("oversize", 64'(got.oversize), 64'(want.oversize));
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [7:0]  i_byte_in;
    logic        o_valid;
    logic        i_stall;
    logic [7:0]  o_data_len;
    logic [2:0]  o_priority_res;
    logic [1:0]  o_edp_dp;
    logic [7:0]  o_pdu_format;
    logic [7:0]  o_pdu_specific;
    logic [17:0] o_group_number;
    logic [7:0]  o_source_addr;
    logic [63:0] o_payload;
    logic        o_oversize;

    j1939_frame_model model;

    bit quiet;      // final stretch: no idling on either side
    bit gappy;      // sender may idle between bytes of this frame
    bit hold_req;   // ask the receiver for one long hold-off
    int bytes_sent;

    can_j1939_frame_deframer_top u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_byte_in      (i_byte_in),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_data_len     (o_data_len),
        .o_priority_res (o_priority_res),
        .o_edp_dp       (o_edp_dp),
        .o_pdu_format   (o_pdu_format),
        .o_pdu_specific (o_pdu_specific),
        .o_group_number (o_group_number),
        .o_source_addr  (o_source_addr),
        .o_payload      (o_payload),
        .o_oversize     (o_oversize)
    );

    // 2 ns clock
    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    // Offer one byte, with an optional idle burst ahead of it; returns on the accept edge
    task automatic send_byte(input logic [7:0] b);
        if (!quiet && gappy && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_byte_in <= b;
        do @(posedge i_clk); while (o_stall);
        model.take_byte(b);
        bytes_sent++;
    endtask

    // Length byte, identifier LSB first, then len data bytes
    task automatic send_frame(input logic [7:0] len, input logic [31:0] id,
                              input logic [63:0] head);
        send_byte(len);
        for (int k = 0; k < 4; k++)
            send_byte(id[8*k +: 8]);
        for (int k = 0; k < int'(len); k++)
            send_byte(k < 8 ? head[8*k +: 8] : 8'($urandom_range(0, 255)));
    endtask

    // Stop offering until every pending frame has come out
    task automatic drain();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (model.decoded.size() != 0);
    endtask

    // Receiver: random stall bursts, one long hold-off on request, none at the end
    initial begin
        i_stall <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (quiet) begin
                i_stall <= 1'b0;
                @(posedge i_clk);
            end else if (hold_req) begin
                i_stall  <= 1'b1;
                hold_req = 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else begin
                case ($urandom_range(0, 5))
                    0, 1: begin
                        i_stall <= 1'b1;
                        repeat ($urandom_range(1, 10)) @(posedge i_clk);
                    end
                    2: begin
                        i_stall <= 1'b0;
                        repeat ($urandom_range(30, 60)) @(posedge i_clk);
                    end
                    default: begin
                        i_stall <= 1'b0;
                        repeat ($urandom_range(1, 10)) @(posedge i_clk);
                    end
                endcase
            end
        end
    end

    // Output monitor: every accepted transaction goes to the scoreboard
    always @(posedge i_clk) begin : mon
        t_frame got;
        if (i_rst_n && o_valid && !i_stall) begin
            got.data_len = o_data_len;
            got.prio     = o_priority_res;
            got.edp_dp   = o_edp_dp;
            got.pf       = o_pdu_format;
            got.ps       = o_pdu_specific;
            got.pgn      = o_group_number;
            got.sa       = o_source_addr;
            got.payload  = o_payload;
            got.oversize = o_oversize;
            model.match_frame(got);
        end
    end

    // Main sequence
    initial begin : stim
        logic [7:0]  len;
        logic [31:0] id;
        logic [63:0] head;
        int          frames;
        bit          hold_done;
        bit          pause_done;
        int          r;

        model      = new();
        quiet      = 1'b0;
        gappy      = 1'b1;
        hold_req   = 1'b0;
        bytes_sent = 0;
        frames     = 0;
        hold_done  = 1'b0;
        pause_done = 1'b0;
        i_rst_n   <= 1'b0;
        i_valid   <= 1'b0;
        i_byte_in <= 8'h00;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: zero length with all-ones id, PDU1 just below the boundary, PDU2 at it
        send_frame(8'd0, 32'hFFFF_FFFF, 64'd0);
        send_frame(8'd1, 32'h1CEF_A5C3, 64'd0);
        send_frame(8'd8, 32'h03F0_5A80, 64'h7F01_FE80_0180_00FF);

        // Random frames: mostly short, some oversize, a few very long
        while (bytes_sent < N_BYTES) begin
            r = $urandom_range(0, 99);
            if (r < 60)
                len = 8'($urandom_range(0, 8));
            else if (r < 90)
                len = 8'($urandom_range(9, 16));
            else if (r < 99)
                len = 8'($urandom_range(17, 40));
            else
                len = 8'($urandom_range(41, 255));
            if (frames == 4)
                len = 8'd255;
            id = $urandom;
            case ($urandom_range(0, 5))
                0: id[23:16] = PDU2_FIRST_PF - 8'd1;
                1: id[23:16] = PDU2_FIRST_PF;
                2: id[23:16] = 8'hFF;
                3: id[23:16] = 8'h00;
                default: ;
            endcase
            head  = {$urandom, $urandom};
            gappy = ($urandom_range(0, 2) != 0);

            if (bytes_sent > 300 && !hold_done) begin
                hold_req  = 1'b1;
                hold_done = 1'b1;
            end
            if (bytes_sent > 800 && !pause_done) begin
                drain();
                pause_done = 1'b1;
            end
            if (bytes_sent > 1300)
                quiet = 1'b1;

            send_frame(len, id, head);
            frames++;
        end

        // Let the last frames come out, wait out the tail, then report
        drain();
        repeat (TAIL_WAIT) @(posedge i_clk);
        if (model.decoded.size() != 0)
            model.flag($sformatf("%0d frames never came out", model.decoded.size()));
        if (model.mismatch_cnt == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Watchdog
    initial begin
        #400000;
        $display("tb: failure");
        $finish;
    end

endmodule

[filelist.f]
+incdir+design
design/cjd_pkg.sv
design/cjd_front.sv
design/cjd_queue.sv
design/cjd_back.sv
design/can_j1939_frame_deframer_top.sv
verif/can_j1939_frame_deframer_top_tb.sv
